### rtl/core/twtt_pkg.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// twtt_pkg
// Shared widths, operation codes and the slot record of the wake-up timer table.
// ----------------------------------------------------------------------------
package twtt_pkg;

   localparam int FUNC_W      = 2;
   localparam int TASK_W      = 5;
   localparam int ARG_W       = 31;
   localparam int TICK_W      = 32;
   localparam int NUM_TASKS_DEF = 32;

   typedef enum logic [FUNC_W-1:0] {
      FUNC_TICK  = 2'd0,
      FUNC_TIME  = 2'd1,
      FUNC_DELAY = 2'd2,
      FUNC_UNTIL = 2'd3
   } func_type;

   typedef enum logic {
      KIND_WAKE  = 1'b0,
      KIND_QUERY = 1'b1
   } kind_type;

   typedef struct packed {
      logic              pending;
      logic [TICK_W-1:0] wake;
   } slot_type;

endpackage

### rtl/core/twtt_req_if.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// twtt_req_if
// Request channel: valid/ready handshake with operation, task slot and argument.
// ----------------------------------------------------------------------------
interface twtt_req_if;
   logic                          valid;
   logic                          ready;
   logic [twtt_pkg::FUNC_W-1:0]   func;
   logic [twtt_pkg::TASK_W-1:0]   task_id;
   logic [twtt_pkg::ARG_W-1:0]    tick_arg;

   modport source (output valid, output func, output task_id, output tick_arg,
                   input ready);
   modport sink   (input valid, input func, input task_id, input tick_arg,
                   output ready);
endinterface

### rtl/core/twtt_rsp_if.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// twtt_rsp_if
// Reply channel: valid/ready handshake carrying one wake or query reply.
// ----------------------------------------------------------------------------
interface twtt_rsp_if;
   logic                          valid;
   logic                          ready;
   logic [twtt_pkg::TASK_W-1:0]   reply_task;
   logic [twtt_pkg::TICK_W-1:0]   reply_ticks;
   logic                          reply_kind;
   logic                          last;

   modport source (output valid, output reply_task, output reply_ticks,
                   output reply_kind, output last, input ready);
   modport sink   (input valid, input reply_task, input reply_ticks,
                   input reply_kind, input last, output ready);
endinterface

### rtl/core/task_wakeup_timer_table.sv
`timescale 1ns / 1ps
// Sequence: a request beat is taken in idle, the scan rotates the slot ring past the
// compare at its head, then the flush state sends the last held wake reply and applies
// the op, or the query state answers a time query. A new request is taken only back in
// idle; the scan and the flush both wait while the reply side stalls.
// Reset: tick count goes to zero and every pending mark clears at once; wake times
// are left as they are and count only while their pending mark is set.
// ----------------------------------------------------------------------------
// task_wakeup_timer_table
// Tick counter plus a ring of task slots that are woken when their time is due.
// ----------------------------------------------------------------------------
module task_wakeup_timer_table #(
   parameter int NUM_TASKS = twtt_pkg::NUM_TASKS_DEF
) (
   input  logic         clock,
   input  logic         reset,
   twtt_req_if.sink     req_bus,
   twtt_rsp_if.source   rsp_bus
);

   localparam int CNT_W = (NUM_TASKS > 1) ? $clog2(NUM_TASKS) : 1;

   typedef enum logic [3:0] {
      ST_IDLE  = 4'b0001,
      ST_SCAN  = 4'b0010,
      ST_FLUSH = 4'b0100,
      ST_QUERY = 4'b1000
   } state_type;

   state_type                          state_ff, state_in;
   logic [twtt_pkg::TICK_W-1:0]        tick_ff, tick_in;
   logic [CNT_W-1:0]                   cnt_ff, cnt_in;

   // latched request
   twtt_pkg::func_type                 func_ff, func_in;
   logic [twtt_pkg::TASK_W-1:0]        task_ff, task_in;
   logic [twtt_pkg::ARG_W-1:0]         arg_ff, arg_in;

   // one wake reply held back until we know whether it is the final beat
   logic                               held_vld_ff, held_vld_in;
   logic [twtt_pkg::TASK_W-1:0]        held_task_ff, held_task_in;

   // reply output register
   logic                               out_vld_ff, out_vld_in;
   logic [twtt_pkg::TASK_W-1:0]        out_task_ff, out_task_in;
   logic [twtt_pkg::TICK_W-1:0]        out_ticks_ff, out_ticks_in;
   twtt_pkg::kind_type                 out_kind_ff, out_kind_in;
   logic                               out_last_ff, out_last_in;

   twtt_pkg::slot_type                 slots [NUM_TASKS];
   twtt_pkg::slot_type                 tail_slot;
   logic                               shift;
   logic                               arm_en;
   logic [twtt_pkg::TICK_W-1:0]        arm_time;
   logic                               head_hit;
   logic                               out_free;
   logic                               req_take;

   assign req_take = req_bus.valid && (state_ff == ST_IDLE);
   assign req_bus.ready = (state_ff == ST_IDLE);
   assign out_free = !out_vld_ff || rsp_bus.ready;

   // compare the slot now at the head of the ring against the current count
   assign head_hit = slots[0].pending && (slots[0].wake <= tick_ff);

   // head wraps around to the tail, its mark dropped when it fires
   assign tail_slot.pending = slots[0].pending && !(head_hit && shift);
   assign tail_slot.wake    = slots[0].wake;

   assign arm_time = (func_ff == twtt_pkg::FUNC_DELAY)
                   ? tick_ff + {1'b0, arg_ff}
                   : {1'b0, arg_ff};

   // ---------------------------------------------------------------------
   // Ring of slot cells; after a full rotation every slot is home again
   // ---------------------------------------------------------------------
   for (genvar gi = 0; gi < NUM_TASKS; gi++) begin : g_cell
      twtt_pkg::slot_type nxt;
      logic               sel;

      if (gi == NUM_TASKS - 1) begin : g_tail
         assign nxt = tail_slot;
      end else begin : g_mid
         assign nxt = slots[gi+1];
      end

      // task_id is 5 bits, so cells beyond 31 are never selected
      assign sel = arm_en && ({{(32-twtt_pkg::TASK_W){1'b0}}, task_ff} == 32'(gi));

      twtt_cell u_cell (
         .clock     (clock),
         .reset     (reset),
         .shift     (shift),
         .next_slot (nxt),
         .arm       (sel),
         .arm_time  (arm_time),
         .slot      (slots[gi])
      );
   end

   // ---------------------------------------------------------------------
   // Sequencer
   // ---------------------------------------------------------------------
   always_comb begin
      state_in     = state_ff;
      tick_in      = tick_ff;
      cnt_in       = cnt_ff;
      func_in      = func_ff;
      task_in      = task_ff;
      arg_in       = arg_ff;
      held_vld_in  = held_vld_ff;
      held_task_in = held_task_ff;
      out_vld_in   = out_vld_ff && !rsp_bus.ready;
      out_task_in  = out_task_ff;
      out_ticks_in = out_ticks_ff;
      out_kind_in  = out_kind_ff;
      out_last_in  = out_last_ff;
      shift        = 1'b0;
      arm_en       = 1'b0;

      case (state_ff)
         ST_IDLE: begin
            if (req_take) begin
               func_in  = twtt_pkg::func_type'(req_bus.func);
               task_in  = req_bus.task_id;
               arg_in   = req_bus.tick_arg;
               cnt_in   = '0;
               state_in = ST_SCAN;
            end
         end
         ST_SCAN: begin
            // stall the ring only when a hit must push out a held reply while the output is busy
            if (!(head_hit && held_vld_ff && !out_free)) begin
               shift = 1'b1;
               if (head_hit) begin
                  if (held_vld_ff) begin
                     out_vld_in   = 1'b1;
                     out_task_in  = held_task_ff;
                     out_ticks_in = tick_ff;
                     out_kind_in  = twtt_pkg::KIND_WAKE;
                     out_last_in  = 1'b0;
                  end
                  held_vld_in  = 1'b1;
                  held_task_in = twtt_pkg::TASK_W'(cnt_ff);
               end
               if (cnt_ff == CNT_W'(NUM_TASKS - 1)) begin
                  state_in = ST_FLUSH;
               end else begin
                  cnt_in = cnt_ff + 1'b1;
               end
            end
         end
         ST_FLUSH: begin
            if (held_vld_ff) begin
               if (out_free) begin
                  out_vld_in   = 1'b1;
                  out_task_in  = held_task_ff;
                  out_ticks_in = tick_ff;
                  out_kind_in  = twtt_pkg::KIND_WAKE;
                  out_last_in  = (func_ff != twtt_pkg::FUNC_TIME);
                  held_vld_in  = 1'b0;
               end
            end else if (func_ff == twtt_pkg::FUNC_TIME) begin
               state_in = ST_QUERY;
            end else begin
               // apply the operation now that the scan is done
               if (func_ff == twtt_pkg::FUNC_TICK) begin
                  tick_in = tick_ff + 1'b1;
               end else begin
                  arm_en = 1'b1;
               end
               state_in = ST_IDLE;
            end
         end
         ST_QUERY: begin
            if (out_free) begin
               out_vld_in   = 1'b1;
               out_task_in  = task_ff;
               out_ticks_in = tick_ff;
               out_kind_in  = twtt_pkg::KIND_QUERY;
               out_last_in  = 1'b1;
               state_in     = ST_IDLE;
            end
         end
         default: begin
            state_in = ST_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff    <= ST_IDLE;
         tick_ff     <= '0;
         held_vld_ff <= 1'b0;
         out_vld_ff  <= 1'b0;
      end else begin
         state_ff    <= state_in;
         tick_ff     <= tick_in;
         held_vld_ff <= held_vld_in;
         out_vld_ff  <= out_vld_in;
      end
   end

   // payload and scan position carry no reset
   always_ff @(posedge clock) begin
      cnt_ff       <= cnt_in;
      func_ff      <= func_in;
      task_ff      <= task_in;
      arg_ff       <= arg_in;
      held_task_ff <= held_task_in;
      out_task_ff  <= out_task_in;
      out_ticks_ff <= out_ticks_in;
      out_kind_ff  <= out_kind_in;
      out_last_ff  <= out_last_in;
   end

   assign rsp_bus.valid       = out_vld_ff;
   assign rsp_bus.reply_task  = out_task_ff;
   assign rsp_bus.reply_ticks = out_ticks_ff;
   assign rsp_bus.reply_kind  = out_kind_ff;
   assign rsp_bus.last        = out_last_ff;

endmodule

### rtl/core/twtt_cell.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// twtt_cell
// One ring cell: holds a wake time and pending mark, shifts toward the head.
// ----------------------------------------------------------------------------
module twtt_cell (
   input  logic                           clock,
   input  logic                           reset,
   input  logic                           shift,
   input  twtt_pkg::slot_type             next_slot,
   input  logic                           arm,
   input  logic [twtt_pkg::TICK_W-1:0]    arm_time,
   output twtt_pkg::slot_type             slot
);

   logic                          pending_ff, pending_in;
   logic [twtt_pkg::TICK_W-1:0]   wake_ff, wake_in;

   always_comb begin
      pending_in = pending_ff;
      wake_in    = wake_ff;
      if (arm) begin
         pending_in = 1'b1;
         wake_in    = arm_time;
      end else if (shift) begin
         pending_in = next_slot.pending;
         wake_in    = next_slot.wake;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         pending_ff <= 1'b0;
      end else begin
         pending_ff <= pending_in;
      end
   end

   // wake time is only meaningful while pending
   always_ff @(posedge clock) begin
      wake_ff <= wake_in;
   end

   assign slot.pending = pending_ff;
   assign slot.wake    = wake_ff;

endmodule
